// File: rtl/core/tvdb_pkg.sv
package tvdb_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int DEPTH_BITS     = 8;
    localparam int LANE_BITS      = (PIXEL_BITS > DEPTH_BITS) ? PIXEL_BITS : DEPTH_BITS;
    localparam int WEIGHT_BITS    = 16;
    localparam int WSUM_BITS      = WEIGHT_BITS + 1;
    localparam int LIMIT_BITS     = 9;
    localparam int DIFF_BITS      = DEPTH_BITS + LIMIT_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Three colour lanes and one depth lane.
    localparam int LANES       = 4;
    localparam int DEPTH_LANE  = 3;
    // One product stage, one sum stage, one stage per quotient bit.
    localparam int LANE_STAGES = LANE_BITS + 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_LEFT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_RIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_LIMIT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPAINT      = 2'd3;

    localparam logic [1:0] SRC_BLEND = 2'd0;
    localparam logic [1:0] SRC_LEFT  = 2'd1;
    localparam logic [1:0] SRC_RIGHT = 2'd2;
    localparam logic [1:0] SRC_HOLE  = 2'd3;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] left_c0;
        logic [PIXEL_BITS-1:0] left_c1;
        logic [PIXEL_BITS-1:0] left_c2;
        logic [PIXEL_BITS-1:0] right_c0;
        logic [PIXEL_BITS-1:0] right_c1;
        logic [PIXEL_BITS-1:0] right_c2;
        logic [DEPTH_BITS-1:0] left_depth;
        logic [DEPTH_BITS-1:0] right_depth;
        logic                  hole;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_c0;
        logic [PIXEL_BITS-1:0] out_c1;
        logic [PIXEL_BITS-1:0] out_c2;
        logic [DEPTH_BITS-1:0] out_depth;
        logic                  depth_written;
        logic [1:0]            source;
    } t_out_item;

    typedef struct packed {
        logic       depth_written;
        logic [1:0] source;
    } t_side;

    typedef logic [LANES-1:0][LANE_BITS-1:0] t_lane_vec;

endpackage

// File: rtl/core/two_view_depth_blend.sv
// Two-view depth blend: merges one pixel position of two warped views.
// Input channel: i_in_valid / o_in_stall / i_in_item carry the colour
// samples and depths of both views plus the hole flag. Output channel:
// o_out_valid / i_out_stall / o_out_item carry the merged colour, the depth,
// whether the depth is written, and the source code. A transfer happens at a
// clock edge where valid is high and stall is low.
// The pipeline has one select stage, a product stage, a sum stage, one
// divider stage per quotient bit, and the output register. The divider
// resolves one quotient bit per stage, so one pixel is accepted every cycle
// while the input is not stalled.
// The user writes the configuration port through i_cfg_we / i_cfg_index /
// i_cfg_data only while no pixel is in flight; the block does not enforce it.
// A synchronous active-low reset empties the pipeline and loads the default
// weights (1.0 each), close limit 5 and inpaint mode off.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling empty slots; the input stalls only when every
// stage is occupied.
module two_view_depth_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tvdb_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tvdb_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [tvdb_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [tvdb_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import tvdb_pkg::*;

    // Select stage, lane stages, output register.
    localparam int NS = LANE_STAGES + 2;

    logic [WEIGHT_BITS-1:0] r_weight_left, r_weight_right;
    logic [LIMIT_BITS-1:0]  r_close_limit;
    logic                   r_inpaint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_left  <= WEIGHT_BITS'(256);
            r_weight_right <= WEIGHT_BITS'(256);
            r_close_limit  <= LIMIT_BITS'(5);
            r_inpaint      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WEIGHT_LEFT:  r_weight_left  <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_RIGHT: r_weight_right <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_CLOSE_LIMIT:  r_close_limit  <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_INPAINT:      r_inpaint      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A zero weight sum falls back to equal weights of one each. The user
    // must change the weights only while the pipeline is empty, as every
    // divider stage reads them directly; the block does not enforce this.
    logic                   w_zero;
    logic [WEIGHT_BITS-1:0] wa, wb;
    logic [WSUM_BITS-1:0]   ws;

    always_comb begin
        w_zero = (r_weight_left == '0) && (r_weight_right == '0);
        wa = w_zero ? WEIGHT_BITS'(1) : r_weight_left;
        wb = w_zero ? WEIGHT_BITS'(1) : r_weight_right;
        ws = WSUM_BITS'(wa) + WSUM_BITS'(wb);
    end

    // Each stage moves forward when it is empty or when every stage ahead
    // of it is able to move, so bubbles collapse behind a stalled output.
    logic [NS-1:0] r_valid;
    logic [NS-1:0] adv;
    logic          all_full;

    always_comb begin
        all_full = 1'b1;
        for (int k = NS - 1; k >= 0; k--) begin
            all_full = all_full & r_valid[k];
            adv[k]   = !(all_full && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_valid[NS-1];

    t_lane_vec sel_a, sel_b, lane_q;
    t_side     sel_side;
    t_side     r_side [LANE_STAGES];

    tvdb_select u_select (
        .i_clk         (i_clk),
        .i_en          (adv[0]),
        .i_item        (i_in_item),
        .i_close_limit (r_close_limit),
        .i_inpaint     (r_inpaint),
        .o_a           (sel_a),
        .o_b           (sel_b),
        .o_side        (sel_side)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tvdb_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv[LANE_STAGES:1]),
            .i_a   (sel_a[l]),
            .i_b   (sel_b[l]),
            .i_wa  (wa),
            .i_wb  (wb),
            .i_ws  (ws),
            .o_q   (lane_q[l])
        );
    end

    // The source code and depth flag travel beside the lanes.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LANE_STAGES; j++) begin
            if (adv[j+1]) begin
                r_side[j] <= (j == 0) ? sel_side : r_side[(j == 0) ? 0 : j - 1];
            end
        end
    end

    tvdb_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (adv[NS-1]),
        .i_q    (lane_q),
        .i_side (r_side[LANE_STAGES-1]),
        .o_item (o_out_item)
    );

endmodule

// File: rtl/core/tvdb_select.sv
module tvdb_select (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  tvdb_pkg::t_in_item                i_item,
    input  logic [tvdb_pkg::LIMIT_BITS-1:0]   i_close_limit,
    input  logic                              i_inpaint,
    output tvdb_pkg::t_lane_vec               o_a,
    output tvdb_pkg::t_lane_vec               o_b,
    output tvdb_pkg::t_side                   o_side
);
    import tvdb_pkg::*;

    t_lane_vec             r_a, r_b, n_a, n_b;
    t_side                 r_side, n_side;
    logic [DEPTH_BITS-1:0] diff;
    logic                  close, left_near;
    t_lane_vec             lv, rv;

    always_comb begin
        lv[0] = LANE_BITS'(i_item.left_c0);
        lv[1] = LANE_BITS'(i_item.left_c1);
        lv[2] = LANE_BITS'(i_item.left_c2);
        lv[DEPTH_LANE] = LANE_BITS'(i_item.left_depth);
        rv[0] = LANE_BITS'(i_item.right_c0);
        rv[1] = LANE_BITS'(i_item.right_c1);
        rv[2] = LANE_BITS'(i_item.right_c2);
        rv[DEPTH_LANE] = LANE_BITS'(i_item.right_depth);

        left_near = i_item.left_depth > i_item.right_depth;
        diff = left_near ? i_item.left_depth - i_item.right_depth
                         : i_item.right_depth - i_item.left_depth;
        close = DIFF_BITS'(diff) < DIFF_BITS'(i_close_limit);

        // A chosen view is fed to both operands, so the weighted average
        // returns it unchanged; a hole feeds zeros.
        if (i_item.hole) begin
            n_a = '0;
            n_b = '0;
            n_side.depth_written = 1'b0;
            n_side.source = SRC_HOLE;
        end else if (close) begin
            n_a = lv;
            n_b = rv;
            n_side.depth_written = 1'b1;
            n_side.source = SRC_BLEND;
        end else if (left_near) begin
            n_a = lv;
            n_b = lv;
            n_side.depth_written = i_inpaint;
            n_side.source = SRC_LEFT;
        end else begin
            n_a = rv;
            n_b = rv;
            n_side.depth_written = i_inpaint;
            n_side.source = SRC_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_side <= n_side;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_side = r_side;

endmodule

// File: rtl/core/tvdb_lane.sv
module tvdb_lane (
    input  logic                               i_clk,
    input  logic [tvdb_pkg::LANE_STAGES-1:0]   i_en,
    input  logic [tvdb_pkg::LANE_BITS-1:0]     i_a,
    input  logic [tvdb_pkg::LANE_BITS-1:0]     i_b,
    input  logic [tvdb_pkg::WEIGHT_BITS-1:0]   i_wa,
    input  logic [tvdb_pkg::WEIGHT_BITS-1:0]   i_wb,
    input  logic [tvdb_pkg::WSUM_BITS-1:0]     i_ws,
    output logic [tvdb_pkg::LANE_BITS-1:0]     o_q
);
    import tvdb_pkg::*;

    localparam int PW = LANE_BITS + WEIGHT_BITS;
    localparam int XW = LANE_BITS + WSUM_BITS;

    logic [PW-1:0] r_pa, r_pb;
    // Upper part holds the partial remainder, lower part the dividend bits
    // still to shift in, followed by the quotient bits already found.
    logic [XW-1:0] r_x [LANE_BITS+1];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pa <= PW'(i_a) * PW'(i_wa);
            r_pb <= PW'(i_b) * PW'(i_wb);
        end
        if (i_en[1]) begin
            r_x[0] <= XW'(r_pa) + XW'(r_pb);
        end
    end

    // The average never exceeds the larger operand, so the quotient fits
    // in LANE_BITS and the top of the sum is already below the divisor.
    for (genvar k = 0; k < LANE_BITS; k++) begin : g_div
        logic [WSUM_BITS:0]   trial, rem;
        logic                 fits;
        logic [XW-1:0]        n_x;

        always_comb begin
            trial = {r_x[k][XW-1:LANE_BITS], r_x[k][LANE_BITS-1]};
            fits  = trial >= {1'b0, i_ws};
            rem   = fits ? trial - {1'b0, i_ws} : trial;
            n_x   = {rem[WSUM_BITS-1:0], r_x[k][LANE_BITS-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k+2]) begin
                r_x[k+1] <= n_x;
            end
        end
    end

    assign o_q = r_x[LANE_BITS][LANE_BITS-1:0];

endmodule

// File: rtl/core/tvdb_merge.sv
module tvdb_merge (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  tvdb_pkg::t_lane_vec   i_q,
    input  tvdb_pkg::t_side       i_side,
    output tvdb_pkg::t_out_item   o_item
);
    import tvdb_pkg::*;

    t_out_item r_item, n_item;

    always_comb begin
        n_item.out_c0 = i_q[0][PIXEL_BITS-1:0];
        n_item.out_c1 = i_q[1][PIXEL_BITS-1:0];
        n_item.out_c2 = i_q[2][PIXEL_BITS-1:0];
        n_item.out_depth = i_side.depth_written ? i_q[DEPTH_LANE][DEPTH_BITS-1:0]
                                                : '0;
        n_item.depth_written = i_side.depth_written;
        n_item.source = i_side.source;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
